### src/rpdt_pkg.sv
// shared types and constants for the register producer dependency table
// no dependencies
`default_nettype none
package rpdt_pkg;

  localparam int SEQ_W   = 48;
  localparam int SPLIT_W = 4;
  localparam int IDX_W   = 8;

  localparam logic [IDX_W-1:0] NO_REG = 8'd128;

  localparam logic [1:0] CMD_ISSUE = 2'd0;
  localparam logic [1:0] CMD_PEEK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] MODE_LATER = 2'd2;

  typedef struct packed {
    logic               hit;
    logic               stale;
    logic               emit;
    logic [SEQ_W-1:0]   seq;
    logic [SPLIT_W-1:0] cnt;
  } lane_res_t;

  typedef struct packed {
    logic               we;
    logic [SEQ_W-1:0]   seq;
    logic [SPLIT_W-1:0] split;
  } entry_wr_t;

  function automatic logic reg_present(input logic [IDX_W-1:0] r, input logic [IDX_W:0] n);
    reg_present = (r != NO_REG) && ({1'b0, r} < n);
  endfunction

endpackage
`default_nettype wire

### src/rpdt_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module rpdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/rpdt_lane.sv
// one source lane: private copy of the producer table and its age checks
// depends on rpdt_pkg and rpdt_ram
`default_nettype none
module rpdt_lane #(
  parameter int NUM_REGS = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(NUM_REGS)-1:0] rd_addr,
  input  wire rpdt_pkg::entry_wr_t         wr,
  input  wire logic [$clog2(NUM_REGS)-1:0] wr_addr,
  input  wire logic                        ent_ok,
  input  wire logic                        split_ok,
  input  wire logic [rpdt_pkg::SEQ_W-1:0]  seq_num,
  input  wire logic [rpdt_pkg::SEQ_W-1:0]  lowest,
  input  wire logic [7:0]                  offset,
  output rpdt_pkg::lane_res_t              res
);
  import rpdt_pkg::*;

  logic [SEQ_W+SPLIT_W-1:0] rdata;
  logic [SEQ_W-1:0]         p;
  logic                     stale;
  logic                     older;

  rpdt_ram #(
    .WIDTH(SEQ_W + SPLIT_W),
    .DEPTH(NUM_REGS)
  ) u_ram (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr_addr),
    .wdata({wr.split, wr.seq}),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign p     = rdata[SEQ_W-1:0];
  assign stale = ent_ok && (p < lowest);
  assign older = ({1'b0, p} + {{(SEQ_W-7){1'b0}}, offset}) < {1'b0, seq_num};

  always_comb begin
    res.hit   = ent_ok && !stale;
    res.stale = stale;
    res.emit  = ent_ok && !stale && older;
    res.seq   = p;
    res.cnt   = split_ok ? rdata[SEQ_W+SPLIT_W-1:SEQ_W] : '0;
  end

endmodule
`default_nettype wire

### src/register_producer_dependency_table.sv
// top level of the register producer dependency table: lanes, valid bits, sequencer
// depends on rpdt_pkg and rpdt_lane
//
// usage: one item enters on s_axis (tuser = command), results leave on m_axis,
// found and dep_seq in tdata and tlast on the final result of an item.
// issue reads every source in its own lane at once (one table copy per lane),
// then a merge sequencer walks the lanes and sends one dependency per cycle
// while the output register is free, then updates dst_a and dst_b through a
// read state and a write state each. a peek returns one result, and a clear
// or an unknown command returns none. s_axis_tready is high only between
// items; the lane reads and the single write port of each table copy set
// this order of steps.
// reset empties the valid and split marks at once; no sweep is needed.
// a stalled receiver holds the output register and the sequencer waits on it;
// the final result may wait there while the next item is taken.
`default_nettype none
module register_producer_dependency_table #(
  parameter int NUM_REGS    = 128,
  parameter int MAX_SPLIT   = 8,
  parameter int NUM_SOURCES = 3
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // seq_num, lowest_valid_seq, type_offset, vector_mode, src_a, src_b, src_c, dst_a, dst_b
  input  wire logic [151:0] s_axis_tdata,
  // cmd
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // found, dep_seq
  output logic [55:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  import rpdt_pkg::*;

  localparam int AW = $clog2(NUM_REGS);
  localparam int NL = (NUM_SOURCES < 3) ? NUM_SOURCES : 3;
  localparam int LW = (NL > 1) ? $clog2(NL) : 1;
  localparam logic [IDX_W:0]   NREGS = (IDX_W + 1)'(NUM_REGS);
  localparam logic [SPLIT_W-1:0] MAXS = SPLIT_W'(MAX_SPLIT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_PEEK  = 3'd3;
  localparam logic [2:0] S_DRD_A = 3'd4;
  localparam logic [2:0] S_DWR_A = 3'd5;
  localparam logic [2:0] S_DRD_B = 3'd6;
  localparam logic [2:0] S_DWR_B = 3'd7;

  logic [2:0]         state;
  logic [1:0]         cmd_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [SEQ_W-1:0]   low_q;
  logic [7:0]         off_q;
  logic [1:0]         mode_q;
  logic [IDX_W-1:0]   src_q [3];
  logic [IDX_W-1:0]   dst_a_q;
  logic [IDX_W-1:0]   dst_b_q;
  logic [IDX_W-1:0]   in_src [3];
  logic [NUM_REGS-1:0] valid;
  logic [NUM_REGS-1:0] split_ok;
  lane_res_t          lane_out [NL];
  lane_res_t          lres [NL];
  lane_res_t          cur;
  logic [LW-1:0]      lane_sel;
  logic [SPLIT_W-1:0] k;
  logic               later;
  logic               acc;
  logic               out_free;
  logic               emit_go;
  logic               peek_go;
  logic               dwr;
  logic [IDX_W-1:0]   dst_cur;
  logic [IDX_W-1:0]   dst_rd;
  logic               dst_ok;
  logic [SPLIT_W-1:0] split_new;
  entry_wr_t          wr;

  assign s_axis_tready = (state == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign in_src[0] = s_axis_tdata[113:106];
  assign in_src[1] = s_axis_tdata[121:114];
  assign in_src[2] = s_axis_tdata[129:122];

  assign dwr     = (state == S_DWR_A) || (state == S_DWR_B);
  assign dst_cur = (state == S_DWR_B) ? dst_b_q : dst_a_q;
  assign dst_rd  = (state == S_DRD_B) ? dst_b_q : dst_a_q;
  assign dst_ok  = reg_present(dst_cur, NREGS);

  for (genvar i = 0; i < NL; i++) begin : g_lane
    logic [IDX_W-1:0] idx;
    logic             pres;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    assign idx     = (i == 0 && dwr) ? dst_cur : src_q[i];
    assign pres    = reg_present(idx, NREGS);
    assign rd_en   = (acc && (s_axis_tuser == CMD_ISSUE || s_axis_tuser == CMD_PEEK)) ||
                     (i == 0 && (state == S_DRD_A || state == S_DRD_B));
    assign rd_addr = (state == S_IDLE) ? in_src[i][AW-1:0] : dst_rd[AW-1:0];

    rpdt_lane #(
      .NUM_REGS(NUM_REGS)
    ) u_lane (
      .clk     (clk),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .wr_addr (dst_cur[AW-1:0]),
      .ent_ok  (pres && valid[idx[AW-1:0]]),
      .split_ok(pres && split_ok[idx[AW-1:0]]),
      .seq_num (seq_q),
      .lowest  (low_q),
      .offset  (off_q),
      .res     (lane_out[i])
    );
  end

  always_comb begin
    split_new = '0;
    if (mode_q == MODE_LATER) begin
      split_new = (lane_out[0].cnt < MAXS) ? lane_out[0].cnt + 1'b1 : lane_out[0].cnt;
    end
    wr.we    = dwr && dst_ok;
    wr.seq   = (mode_q != MODE_LATER) ? seq_q : lane_out[0].seq;
    wr.split = split_new;
  end

  assign cur = lres[lane_sel];

  always_comb begin
    later = 1'b0;
    for (int j = 0; j < NL; j++) begin
      if (j > int'(lane_sel) && lres[j].emit) begin
        later = 1'b1;
      end
    end
  end

  assign emit_go = (state == S_EMIT) && cur.emit && out_free;
  assign peek_go = (state == S_PEEK) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid         <= '0;
      split_ok      <= '0;
      lane_sel      <= '0;
      k             <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_go || peek_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (emit_go) begin
        m_axis_tdata <= {7'd0, cur.seq + SEQ_W'(k), 1'b1};
        m_axis_tlast <= (k == cur.cnt) && !later;
      end else if (peek_go) begin
        m_axis_tdata <= {7'd0, lres[0].hit ? lres[0].seq : {SEQ_W{1'b0}}, lres[0].hit};
        m_axis_tlast <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cmd_q    <= s_axis_tuser;
            seq_q    <= s_axis_tdata[47:0];
            low_q    <= s_axis_tdata[95:48];
            off_q    <= s_axis_tdata[103:96];
            mode_q   <= s_axis_tdata[105:104];
            src_q[0] <= in_src[0];
            src_q[1] <= in_src[1];
            src_q[2] <= in_src[2];
            dst_a_q  <= s_axis_tdata[137:130];
            dst_b_q  <= s_axis_tdata[145:138];
            if (s_axis_tuser == CMD_ISSUE || s_axis_tuser == CMD_PEEK) begin
              state <= S_READ;
            end else if (s_axis_tuser == CMD_CLEAR) begin
              valid    <= '0;
              split_ok <= '0;
            end
          end
        end
        S_READ: begin
          for (int i = 0; i < NL; i++) begin
            lres[i] <= lane_out[i];
            if (cmd_q == CMD_ISSUE && lane_out[i].stale) begin
              valid[src_q[i][AW-1:0]] <= 1'b0;
            end
          end
          lane_sel <= '0;
          k        <= '0;
          state    <= (cmd_q == CMD_PEEK) ? S_PEEK : S_EMIT;
        end
        S_EMIT: begin
          if (!cur.emit || (emit_go && k == cur.cnt)) begin
            k <= '0;
            if (int'(lane_sel) == NL - 1) begin
              state <= S_DRD_A;
            end else begin
              lane_sel <= lane_sel + 1'b1;
            end
          end else if (emit_go) begin
            k <= k + 1'b1;
          end
        end
        S_PEEK: begin
          if (peek_go) begin
            state <= S_IDLE;
          end
        end
        S_DRD_A: state <= S_DWR_A;
        S_DRD_B: state <= S_DWR_B;
        S_DWR_A, S_DWR_B: begin
          if (dst_ok) begin
            split_ok[dst_cur[AW-1:0]] <= 1'b1;
            if (mode_q != MODE_LATER) begin
              valid[dst_cur[AW-1:0]] <= 1'b1;
            end
          end
          state <= (state == S_DWR_A) ? S_DRD_B : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (acc && s_axis_tuser == CMD_CLEAR) |=> (valid == '0 && split_ok == '0))
    else $error("clear left live entries");

  a_split_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (k <= MAXS))
    else $error("split index beyond maximum");

  a_peek_last: assert property (@(posedge clk) disable iff (rst)
    peek_go |=> (m_axis_tvalid && m_axis_tlast))
    else $error("peek result not marked last");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> !acc)
    else $error("item taken during lookup");
`endif

endmodule
`default_nettype wire
